// ----- rtl/hbv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heading basis package
// Word types, pipeline side data and constants shared by the heading basis
// block and its stage modules.
// ----------------------------------------------------------------------------
package hbv_pkg;

  localparam logic [15:0] Q14_ONE    = 16'd16384;
  localparam logic [15:0] THR_RESET  = 16'd3;
  localparam logic [15:0] SPEED_MAX  = 16'd46341;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS  = 16;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_z;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_z;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_z;
    logic        [15:0] speed;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
    logic               neg_x;
    logic               neg_z;
    logic        [15:0] mag_x;
    logic        [15:0] mag_z;
    logic        [15:0] spd;
    logic               norm;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/heading_basis_from_velocity_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heading basis from velocity
// Computes speed, unit forward and right vectors from a ground-plane velocity.
// ----------------------------------------------------------------------------
// Input words carry velocity and position; each gives exactly one output word
// with right, forward, origin and speed. Both channels use valid and stall.
// The pipeline has 37 register stages: squares, sum, 16 square root digit
// stages, rounding, numerator setup, 16 divider bit stages and the output
// register. A new word is accepted every cycle unless a valid output is
// stalled; the rate is one word per cycle. When the receiver stalls a valid
// output, the whole pipeline holds and the input stall is raised in the same
// cycle, so nothing is lost or repeated. The user must write the speed
// threshold via cfg_we_i and cfg_wdata_i only while idle; the block does not
// enforce it. Reset empties the pipeline and sets the threshold to 3.
// ----------------------------------------------------------------------------
module heading_basis_from_velocity_unit
  import hbv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned SQ0 = 1;
  localparam int unsigned RND = SQ0 + SQRT_STEPS + 1;
  localparam int unsigned NUM = RND + 1;
  localparam int unsigned OUT = NUM + DIV_STEPS + 1;
  localparam int unsigned NST = OUT + 1;

  logic            adv;
  logic [NST-1:0]  vld_q;
  side_t           side_q [NST-1];
  logic [15:0]     thr_q;
  logic [31:0]     sqx_q, sqz_q, sum_q;
  logic [31:0]     prod_x, prod_z;

  logic [31:0]     n_w    [SQRT_STEPS+1];
  logic [15:0]     root_w [SQRT_STEPS+1];
  logic [17:0]     rem_w  [SQRT_STEPS+1];
  logic [31:0]     dx_w   [DIV_STEPS+1];
  logic [31:0]     dz_w   [DIV_STEPS+1];
  logic [15:0]     qx_w   [DIV_STEPS+1];
  logic [15:0]     qz_w   [DIV_STEPS+1];
  logic [31:0]     numx_q, numz_q;

  logic [15:0]     spd_d;
  logic [15:0]     satx, satz;
  logic [15:0]     fx, fz;
  side_t           side_in;
  side_t           side_rnd;
  side_t           side_num;
  side_t           last_s;
  out_word_t       out_d;
  out_word_t       out_q;

  assign adv        = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NST-1];
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_comb begin
    prod_x        = 32'(in_word_i.vel_x * in_word_i.vel_x);
    prod_z        = 32'(in_word_i.vel_z * in_word_i.vel_z);
    side_in       = '0;
    side_in.pos_x = in_word_i.pos_x;
    side_in.pos_z = in_word_i.pos_z;
    side_in.neg_x = in_word_i.vel_x[15];
    side_in.neg_z = in_word_i.vel_z[15];
    side_in.mag_x = in_word_i.vel_x[15] ? 16'(-in_word_i.vel_x) : 16'(in_word_i.vel_x);
    side_in.mag_z = in_word_i.vel_z[15] ? 16'(-in_word_i.vel_z) : 16'(in_word_i.vel_z);
    spd_d = root_w[SQRT_STEPS]
          + {15'b0, (rem_w[SQRT_STEPS] > {2'b0, root_w[SQRT_STEPS]})};
    side_rnd      = side_q[RND-1];
    side_rnd.spd  = spd_d;
    side_num      = side_q[NUM-1];
    side_num.norm = (side_q[NUM-1].spd > thr_q) && (side_q[NUM-1].spd != 16'd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      sqx_q     <= prod_x;
      sqz_q     <= prod_z;
      sum_q     <= sqx_q + sqz_q;
      for (int i = 1; i < NST - 1; i++) begin
        if (i == RND) begin
          side_q[i] <= side_rnd;
        end else if (i == NUM) begin
          side_q[i] <= side_num;
        end else begin
          side_q[i] <= side_q[i-1];
        end
      end
      numx_q <= (32'(side_q[RND].mag_x) << 14) + 32'(side_q[RND].spd >> 1);
      numz_q <= (32'(side_q[RND].mag_z) << 14) + 32'(side_q[RND].spd >> 1);
      out_q  <= out_d;
    end
  end

  assign n_w[0]    = sum_q;
  assign root_w[0] = '0;
  assign rem_w[0]  = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    hbv_sqrt_step u_step (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (n_w[k]),
      .root_i (root_w[k]),
      .rem_i  (rem_w[k]),
      .n_o    (n_w[k+1]),
      .root_o (root_w[k+1]),
      .rem_o  (rem_w[k+1])
    );
  end

  assign dx_w[0] = numx_q;
  assign dz_w[0] = numz_q;
  assign qx_w[0] = '0;
  assign qz_w[0] = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    hbv_div_step #(.BIT(DIV_STEPS - 1 - k)) u_div_x (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (dx_w[k]),
      .q_i   (qx_w[k]),
      .dvs_i (side_q[NUM+k].spd),
      .rem_o (dx_w[k+1]),
      .q_o   (qx_w[k+1])
    );
    hbv_div_step #(.BIT(DIV_STEPS - 1 - k)) u_div_z (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (dz_w[k]),
      .q_i   (qz_w[k]),
      .dvs_i (side_q[NUM+k].spd),
      .rem_o (dz_w[k+1]),
      .q_o   (qz_w[k+1])
    );
  end

  always_comb begin
    last_s = side_q[NST-2];
    satx   = (qx_w[DIV_STEPS] > Q14_ONE) ? Q14_ONE : qx_w[DIV_STEPS];
    satz   = (qz_w[DIV_STEPS] > Q14_ONE) ? Q14_ONE : qz_w[DIV_STEPS];
    if (last_s.norm) begin
      fx = last_s.neg_x ? 16'(-satx) : satx;
      fz = last_s.neg_z ? 16'(-satz) : satz;
    end else begin
      fx = 16'd0;
      fz = Q14_ONE;
    end
    out_d.right_x  = 16'(-fz);
    out_d.right_z  = fx;
    out_d.fwd_x    = fx;
    out_d.fwd_z    = fz;
    out_d.origin_x = last_s.pos_x;
    out_d.origin_z = last_s.pos_z;
    out_d.speed    = last_s.spd;
  end

  a_speed_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.speed <= SPEED_MAX))
    else $error("speed out of range");

  a_right_basis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.right_z == out_word_o.fwd_x)
                 && (out_word_o.right_x == 16'(-out_word_o.fwd_z)))
    else $error("right vector does not match forward vector");

  a_fwd_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_word_o.fwd_x) <= $signed(Q14_ONE))
                 && ($signed(out_word_o.fwd_x) >= -$signed(Q14_ONE))
                 && ($signed(out_word_o.fwd_z) <= $signed(Q14_ONE))
                 && ($signed(out_word_o.fwd_z) >= -$signed(Q14_ONE)))
    else $error("forward component out of range");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

endmodule
`default_nettype wire

// ----- rtl/hbv_sqrt_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square root digit stage
// One registered step of the restoring square root, two radicand bits per step.
// ----------------------------------------------------------------------------
module hbv_sqrt_step (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] n_i,
  input  wire logic [15:0] root_i,
  input  wire logic [17:0] rem_i,
  output logic      [31:0] n_o,
  output logic      [15:0] root_o,
  output logic      [17:0] rem_o
);

  logic [17:0] remx;
  logic [17:0] trial;
  logic        ge;
  logic [31:0] n_d;
  logic [15:0] root_d;
  logic [17:0] rem_d;

  always_comb begin
    remx   = {rem_i[15:0], n_i[31:30]};
    trial  = {root_i, 2'b01};
    ge     = remx >= trial;
    n_d    = {n_i[29:0], 2'b00};
    root_d = {root_i[14:0], ge};
    rem_d  = ge ? (remx - trial) : remx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o    <= n_d;
      root_o <= root_d;
      rem_o  <= rem_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hbv_div_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Division bit stage
// One registered step of the restoring divider, producing one quotient bit.
// ----------------------------------------------------------------------------
module hbv_div_step #(
  parameter int unsigned BIT = 0
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] rem_i,
  input  wire logic [15:0] q_i,
  input  wire logic [15:0] dvs_i,
  output logic      [31:0] rem_o,
  output logic      [15:0] q_o
);

  logic [31:0] trial;
  logic        ge;
  logic [31:0] rem_d;
  logic [15:0] q_d;

  always_comb begin
    trial = {16'b0, dvs_i} << BIT;
    ge    = rem_i >= trial;
    rem_d = ge ? (rem_i - trial) : rem_i;
    q_d   = q_i | ({15'b0, ge} << BIT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      q_o   <= q_d;
    end
  end

endmodule
`default_nettype wire

// ----- dv/heading_basis_from_velocity_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading basis from velocity testbench
// Drives velocity and position words with random idle and stall gaps and
// compares every output word against a speed and unit-heading predictor.
// ----------------------------------------------------------------------------
module heading_basis_from_velocity_unit_tb;
  import hbv_pkg::*;

  localparam int unsigned LATENCY     = 37;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  logic [15:0] threshold_q;
  out_word_t   heading_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_rx = 1'b0;

  heading_basis_from_velocity_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [16:0] root_nearest(logic [31:0] n);
    logic [33:0] r;
    logic [33:0] bitv;
    logic [33:0] x;
    r = '0;
    x = n;
    bitv = 34'd1 << 30;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (x > r) r = r + 1;
    return r[16:0];
  endfunction

  function automatic logic signed [15:0] unit_part(logic signed [15:0] v, logic [16:0] spd);
    logic [31:0] mag;
    logic [47:0] q;
    mag = (v < 0) ? -32'(v) : 32'(v);
    q = (48'(mag) * 48'd16384 + 48'(spd / 2)) / 48'(spd);
    if (q > 48'd16384) q = 48'd16384;
    return (v < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic out_word_t heading_of(in_word_t w);
    out_word_t o;
    logic [31:0] sum;
    logic [16:0] spd;
    logic signed [15:0] fx;
    logic signed [15:0] fz;
    sum = 32'(int'(w.vel_x) * int'(w.vel_x)) + 32'(int'(w.vel_z) * int'(w.vel_z));
    spd = root_nearest(sum);
    fx = 16'sd0;
    fz = 16'sd16384;
    if (spd > 17'(threshold_q) && spd != 0) begin
      fx = unit_part(w.vel_x, spd);
      fz = unit_part(w.vel_z, spd);
    end
    o.right_x = -fz;
    o.right_z = fx;
    o.fwd_x = fx;
    o.fwd_z = fz;
    o.origin_x = w.pos_x;
    o.origin_z = w.pos_z;
    o.speed = spd[15:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (heading_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = heading_q.pop_front();
        if (out_word_o.right_x !== e.right_x) report_mismatch("right_x", out_word_o.right_x, e.right_x);
        if (out_word_o.right_z !== e.right_z) report_mismatch("right_z", out_word_o.right_z, e.right_z);
        if (out_word_o.fwd_x !== e.fwd_x) report_mismatch("fwd_x", out_word_o.fwd_x, e.fwd_x);
        if (out_word_o.fwd_z !== e.fwd_z) report_mismatch("fwd_z", out_word_o.fwd_z, e.fwd_z);
        if (out_word_o.origin_x !== e.origin_x)
          report_mismatch("origin_x", out_word_o.origin_x, e.origin_x);
        if (out_word_o.origin_z !== e.origin_z)
          report_mismatch("origin_z", out_word_o.origin_z, e.origin_z);
        if (out_word_o.speed !== e.speed) report_mismatch("speed", out_word_o.speed, e.speed);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (idle_on) out_stall_i <= ($urandom_range(99) < 35);
    else out_stall_i <= 1'b0;
  end

  task automatic send_word(in_word_t w);
    if (idle_on) begin
      while ($urandom_range(99) < 35) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    heading_q.push_back(heading_of(w));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic in_word_t vel_word(int vx, int vz);
    in_word_t w;
    w.vel_x = 16'(vx);
    w.vel_z = 16'(vz);
    w.pos_x = 24'($urandom);
    w.pos_z = 24'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w = vel_word($urandom, $urandom);
    case ($urandom_range(3))
      0: begin
        w.vel_x = 16'($signed(8'($urandom)));
        w.vel_z = 16'($signed(8'($urandom)));
      end
      1: begin
        w.vel_x = 16'($signed(4'($urandom)));
        w.vel_z = 16'($signed(4'($urandom)));
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_q = v;
  endtask

  task automatic test_directed();
    send_word(vel_word(0, 0));
    send_word(vel_word(1, 0));
    send_word(vel_word(3, 0));
    send_word(vel_word(4, 0));
    send_word(vel_word(0, -4));
    send_word(vel_word(-32768, -32768));
    send_word(vel_word(32767, 32767));
    send_word(vel_word(-32768, 32767));
    send_word(vel_word(32767, 0));
    send_word(vel_word(0, -32768));
    send_word(vel_word(1, 1));
    send_word(vel_word(-1, -1));
    send_word(vel_word(3, 4));
    send_word(vel_word(-256, 0));
    begin
      in_word_t w;
      w = vel_word(256, 256);
      w.pos_x = 24'h7FFFFF; w.pos_z = 24'h800000;
      send_word(w);
      w.pos_x = 24'h800000; w.pos_z = 24'h7FFFFF;
      send_word(w);
      w.pos_x = 24'hFFFFFF; w.pos_z = 24'h000000;
      send_word(w);
    end
    drain();
  endtask

  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    send_word(vel_word(1, 0));
    send_word(vel_word(0, 0));
    repeat (20) send_word(random_word());
    drain();
    write_threshold(16'hFFFF);
    repeat (20) send_word(random_word());
    drain();
    write_threshold(16'd46341);
    send_word(vel_word(-32768, -32768));
    send_word(vel_word(32767, 32767));
    drain();
    write_threshold(16'd3);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1400; i++) begin
      if (i == 300) idle_on = 1'b0;
      if (i == 500) idle_on = 1'b1;
      if (i % 350 == 349) begin
        drain();
        write_threshold(16'($urandom_range(600)));
      end
      send_word(random_word());
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (80) send_word(random_word());
    join
    drain();
  endtask

  initial begin
    threshold_q = THR_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_extremes();
    test_backpressure();
    test_random();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hbv_pkg.sv
rtl/hbv_sqrt_step.sv
rtl/hbv_div_step.sv
rtl/heading_basis_from_velocity_unit.sv
dv/heading_basis_from_velocity_unit_tb.sv
